FILE: src/dts_pkg.sv
// dts_pkg: types, codes and helper functions of the transfer slot scheduler
// used by the front, engine, result buffer and top modules; depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package dts_pkg;

  localparam int NPORTS      = 5;
  localparam int MAX_RESULTS = 9;
  localparam int CYC_W       = 48;

  typedef enum logic [1:0] {
    OP_ISSUE  = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_ACCEPTED    = 3'd0,
    K_NO_CREDIT   = 3'd1,
    K_ERROR       = 3'd2,
    K_CANCELLED   = 3'd3,
    K_CANCEL_FAIL = 3'd4,
    K_COMPLETED   = 3'd5,
    K_PASS_DONE   = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    PH_FREE   = 2'd0,
    PH_LAUNCH = 2'd1,
    PH_WAIT   = 2'd2,
    PH_XMIT   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEARCH, ST_SCAN, ST_ADMIT, ST_PICK, ST_DIV, ST_DIVW, ST_FINAL
  } state_t;

  typedef enum logic [2:0] {
    CFG_FINE      = 3'd0,
    CFG_CHANNELS  = 3'd1,
    CFG_LAUNCH    = 3'd2,
    CFG_BUS_W     = 3'd3,
    CFG_SPM_RD_W  = 3'd4,
    CFG_SPM_WR_W  = 3'd5,
    CFG_AXI_RD_W  = 3'd6,
    CFG_AXI_WR_W  = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    DIR_SPM_REMOTE  = 3'd0,
    DIR_REMOTE_SPM  = 3'd1,
    DIR_SPM_SPM     = 3'd2,
    DIR_SPM_DRAM    = 3'd3,
    DIR_DRAM_SPM    = 3'd4,
    DIR_DRAM_REMOTE = 3'd5
  } dir_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] payload_size;
    logic [2:0]  direction;
    logic [31:0] target_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] transfer_id;
    logic [1:0]  channel;
    logic [0:0]  slot_in_chan;
    logic [4:0]  busy_ports;
    logic [4:0]  inflight;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        fine;
    logic [2:0]  chan_cnt;
    logic [15:0] launch;
    logic [12:0] bus_w;
    logic [12:0] spm_rd_w;
    logic [12:0] spm_wr_w;
    logic [12:0] axi_rd_w;
    logic [12:0] axi_wr_w;
  } cfg_t;

  // classified word handed from front to engine
  typedef struct packed {
    op_t         op;
    logic [31:0] bits;
    logic [4:0]  mask;
    logic        err;
    logic [31:0] tid;
  } cmd_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] bits;
    logic [4:0]  mask;
  } xfer_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] id;
    logic [1:0]  chan;
    logic [0:0]  cslot;
  } rec_t;

  // engine to result buffer
  typedef struct packed {
    logic        wr;
    logic        commit;
    rec_t        rec;
    logic [4:0]  busy;
    logic [4:0]  inflight;
  } rb_wr_t;

  // port set of each direction in fine-grained mode
  function automatic logic [4:0] fine_mask(input logic [2:0] dir);
    logic [4:0] m;
    unique case (dir)
      DIR_SPM_REMOTE:  m = 5'h02;
      DIR_REMOTE_SPM:  m = 5'h04;
      DIR_SPM_SPM:     m = 5'h06;
      DIR_SPM_DRAM:    m = 5'h12;
      DIR_DRAM_SPM:    m = 5'h0C;
      DIR_DRAM_REMOTE: m = 5'h08;
      default:         m = 5'h00;
    endcase
    return m;
  endfunction

  // width of a port, zero taken as one
  function automatic logic [12:0] port_width(input cfg_t c, input logic [2:0] p);
    logic [12:0] w;
    unique case (p)
      3'd0:    w = c.bus_w;
      3'd1:    w = c.spm_rd_w;
      3'd2:    w = c.spm_wr_w;
      3'd3:    w = c.axi_rd_w;
      default: w = c.axi_wr_w;
    endcase
    return (w == 13'd0) ? 13'd1 : w;
  endfunction

  // done time reached when now - done, modulo 2^48, is below 2^47
  function automatic logic reached(input logic [CYC_W-1:0] now,
                                   input logic [CYC_W-1:0] done);
    logic [CYC_W-1:0] d;
    d = now - done;
    return !d[CYC_W-1];
  endfunction

endpackage
`default_nettype wire

FILE: src/dts_front.sv
// dts_front: input queue of two words that checks and classifies issue words
// depends on dts_pkg
`timescale 1ns / 1ps
`default_nettype none
module dts_front (
  input  logic              clk,
  input  logic              rst_n,
  input  dts_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  dts_pkg::in_item_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output dts_pkg::cmd_t     cmd
);
  import dts_pkg::*;

  cmd_t       q_r [2];
  logic [1:0] qc_r;
  cmd_t       cls;
  logic       push, pop;

  // classify the incoming word
  always_comb begin
    cls.op   = op_t'(in_data.operation);
    cls.bits = in_data.payload_size;
    cls.tid  = in_data.target_id;
    cls.mask = cfg.fine ? fine_mask(in_data.direction) : 5'h01;
    cls.err  = (in_data.payload_size == 32'd0) || (in_data.direction > DIR_DRAM_REMOTE) ||
               (!cfg.fine && (in_data.direction > DIR_REMOTE_SPM));
  end

  assign in_stall  = (qc_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (qc_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[0];

  // queue storage
  always_ff @(posedge clk) begin
    if (pop) begin
      q_r[0] <= q_r[1];
    end
    if (push) begin
      if (pop) begin
        if (qc_r == 2'd1) q_r[0] <= cls;
        else q_r[1] <= cls;
      end else begin
        if (qc_r == 2'd0) q_r[0] <= cls;
        else q_r[1] <= cls;
      end
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qc_r <= 2'd0;
    end else begin
      qc_r <= qc_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: src/dts_div.sv
// dts_div: restoring divider, one quotient bit a cycle, for service lengths
// depends on nothing outside this file
`timescale 1ns / 1ps
`default_nettype none
module dts_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [12:0] divisor,
  output logic        done,
  output logic [32:0] quo
);
  localparam int STEPS = 33;

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [12:0] rem_r;
  logic [32:0] q_r;
  logic [12:0] dvs_r;
  logic [13:0] trial;
  logic        ge;
  logic        done_r;

  assign trial = {rem_r, q_r[32]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign done  = done_r;
  assign quo   = q_r;

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? 13'(trial - {1'b0, dvs_r}) : trial[12:0];
      q_r   <= {q_r[31:0], ge};
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/dts_rbuf.sv
// dts_rbuf: result buffer that collects one item's records and sends them out
// depends on dts_pkg
`timescale 1ns / 1ps
`default_nettype none
module dts_rbuf (
  input  logic               clk,
  input  logic               rst_n,
  input  dts_pkg::rb_wr_t    rb_wr,
  output logic               rb_empty,
  output logic               out_valid,
  input  logic               out_stall,
  output dts_pkg::out_item_t out_data
);
  import dts_pkg::*;

  localparam int IW = $clog2(MAX_RESULTS + 1);

  rec_t          rec_r [MAX_RESULTS];
  logic [IW-1:0] cnt_r, rd_r;
  logic          drain_r;
  logic [4:0]    busy_r, infl_r;
  logic          take, is_last;
  rec_t          cur;

  assign cur       = rec_r[rd_r[$clog2(MAX_RESULTS)-1:0]];
  assign is_last   = (rd_r == cnt_r - IW'(1));
  assign out_valid = drain_r;
  assign take      = drain_r && !out_stall;
  assign rb_empty  = !drain_r && (cnt_r == '0);

  always_comb begin
    out_data.kind         = cur.kind;
    out_data.transfer_id  = cur.id;
    out_data.channel      = cur.chan;
    out_data.slot_in_chan = cur.cslot;
    out_data.busy_ports   = busy_r;
    out_data.inflight     = infl_r;
    out_data.last         = is_last;
  end

  // record storage
  always_ff @(posedge clk) begin
    if (rb_wr.wr) begin
      rec_r[cnt_r[$clog2(MAX_RESULTS)-1:0]] <= rb_wr.rec;
    end
    if (rb_wr.commit) begin
      busy_r <= rb_wr.busy;
      infl_r <= rb_wr.inflight;
    end
  end

  // fill and drain control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      rd_r    <= '0;
      drain_r <= 1'b0;
    end else begin
      if (rb_wr.wr) begin
        cnt_r <= cnt_r + IW'(1);
      end
      if (rb_wr.commit) begin
        drain_r <= 1'b1;
      end
      if (take) begin
        if (is_last) begin
          cnt_r   <= '0;
          rd_r    <= '0;
          drain_r <= 1'b0;
        end else begin
          rd_r <= rd_r + IW'(1);
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_last_is_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |-> (out_data.kind == K_PASS_DONE))
    else $error("final record is not pass done");
  a_no_wr_drain: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> !rb_wr.wr)
    else $error("record written while draining");
  a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    rb_wr.commit |=> !rb_empty)
    else $error("commit left buffer empty");
`endif

endmodule
`default_nettype wire

FILE: src/dts_engine.sv
// dts_engine: back end that runs issue, cancel and tick words and the slot pass
// depends on dts_pkg and dts_div
`timescale 1ns / 1ps
`default_nettype none
module dts_engine #(
  parameter int MAX_CHANNELS      = 4,
  parameter int SLOTS_PER_CHANNEL = 2,
  parameter int PENDING_DEPTH     = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dts_pkg::cfg_t   cfg,
  input  dts_pkg::cmd_t   cmd,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  logic            rb_empty,
  output dts_pkg::rb_wr_t rb_wr
);
  import dts_pkg::*;

  localparam int NSLOTS = MAX_CHANNELS * SLOTS_PER_CHANNEL;
  localparam int SW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int CW     = $clog2(NSLOTS + 1);
  localparam int PW     = $clog2(PENDING_DEPTH + 1);
  localparam int PIW    = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int SBW    = (SLOTS_PER_CHANNEL > 1) ? $clog2(SLOTS_PER_CHANNEL) : 1;
  localparam int CHW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CHN_W  = $clog2(MAX_CHANNELS + 1);

  state_t           st_r, st_nxt;
  logic [CYC_W-1:0] cycle_now_r;
  logic [31:0]      next_id_r;
  xfer_t            pend_r [PENDING_DEPTH];
  logic [PW-1:0]    pend_cnt_r;
  phase_t           phase_r [NSLOTS];
  xfer_t            sinfo_r [NSLOTS];
  logic [CYC_W-1:0] launch_done_r [NSLOTS];
  logic [CYC_W-1:0] port_done_r [NPORTS];
  logic [SW-1:0]    owner_r [NPORTS];
  logic [NPORTS-1:0] owner_vld_r;
  logic [SW-1:0]    last_served_r;
  logic [CW-1:0]    active_r;

  logic [CW-1:0]    idx_r;
  logic [SBW-1:0]   sub_r;
  logic [CHW-1:0]   chan_r;
  logic [PW-1:0]    pidx_r;
  logic [31:0]      tid_r;
  logic             prog_r;
  logic [3:0]       nrec_r;
  logic [SW-1:0]    rr_r;
  logic [CW-1:0]    rr_cnt_r;
  logic [2:0]       pp_r;

  logic [SW-1:0]    cur_s;
  logic             scan_last;
  logic [NPORTS-1:0] own, fr;
  logic             xmit_done, launch_ok, cmp_emit;
  logic             srch_end, srch_hit;
  logic [CHN_W-1:0] cc_lim;
  logic [CW-1:0]    used_c;
  logic             adm_go, adm_free;
  logic             rr_ok, pick_end;
  logic [7:0]       mk8;
  logic             pp_end, pp_use;
  logic             credit_fail, id_full, acc_ok, take;
  logic             pop_en;
  logic [PW-1:0]    pop_at;
  logic             div_start, div_done;
  logic [32:0]      div_q;
  logic [12:0]      pw_sel;

  function automatic logic [SW-1:0] rr_inc(input logic [SW-1:0] x);
    return (x == SW'(NSLOTS - 1)) ? '0 : x + SW'(1);
  endfunction

  // slot scan conditions
  always_comb begin
    cur_s     = idx_r[SW-1:0];
    scan_last = (idx_r == CW'(NSLOTS - 1));
    for (int p = 0; p < NPORTS; p++) begin
      own[p] = owner_vld_r[p] && (owner_r[p] == cur_s);
      fr[p]  = own[p] && reached(cycle_now_r, port_done_r[p]);
    end
    xmit_done = (phase_r[cur_s] == PH_XMIT) && ((own & ~fr) == '0);
    launch_ok = (phase_r[cur_s] == PH_LAUNCH) && reached(cycle_now_r, launch_done_r[cur_s]);
    cmp_emit  = xmit_done && (nrec_r < 4'(MAX_RESULTS - 1));
  end

  // used slots from the channel count
  always_comb begin
    if (cfg.chan_cnt == 3'd0) cc_lim = CHN_W'(1);
    else if (32'(cfg.chan_cnt) > MAX_CHANNELS) cc_lim = CHN_W'(MAX_CHANNELS);
    else cc_lim = CHN_W'(cfg.chan_cnt);
    used_c   = CW'(32'(cc_lim) * SLOTS_PER_CHANNEL);
    adm_go   = (idx_r < used_c) && (pend_cnt_r != '0);
    adm_free = (phase_r[cur_s] == PH_FREE);
  end

  // cancel search, round robin pick, port iteration
  always_comb begin
    srch_end = (pidx_r == pend_cnt_r);
    srch_hit = (pend_r[pidx_r[PIW-1:0]].id == tid_r);
    rr_ok    = (phase_r[rr_r] == PH_WAIT) && ((owner_vld_r & sinfo_r[rr_r].mask) == '0);
    pick_end = (rr_cnt_r == CW'(NSLOTS - 1));
    mk8      = 8'(sinfo_r[last_served_r].mask);
    pp_end   = (pp_r == 3'(NPORTS));
    pp_use   = !pp_end && mk8[pp_r];
    pw_sel   = port_width(cfg, pp_r);
  end

  // issue admission checks
  always_comb begin
    credit_fail = ((32'(pend_cnt_r) + 32'(active_r)) >= (32'(used_c) + PENDING_DEPTH)) ||
                  (32'(pend_cnt_r) >= PENDING_DEPTH);
    id_full     = (next_id_r == 32'hFFFF_FFFF);
    acc_ok      = !cmd.err && !credit_fail && !id_full;
    take        = cmd_valid && cmd_ready;
    pop_en      = ((st_r == ST_SEARCH) && !srch_end && srch_hit) ||
                  ((st_r == ST_ADMIT) && adm_go && adm_free);
    pop_at      = (st_r == ST_SEARCH) ? pidx_r : '0;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:   if (take) st_nxt = (cmd.op == OP_CANCEL) ? ST_SEARCH : ST_SCAN;
      ST_SEARCH: if (srch_end || srch_hit) st_nxt = ST_SCAN;
      ST_SCAN:   if (scan_last) st_nxt = ST_ADMIT;
      ST_ADMIT:  if (!adm_go) st_nxt = ST_PICK;
      ST_PICK: begin
        if (rr_ok) st_nxt = ST_DIV;
        else if (pick_end) st_nxt = prog_r ? ST_SCAN : ST_FINAL;
      end
      ST_DIV: begin
        if (pp_end) st_nxt = ST_PICK;
        else if (pp_use) st_nxt = ST_DIVW;
      end
      ST_DIVW:   if (div_done) st_nxt = ST_DIV;
      ST_FINAL:  st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // outputs: handshake, records, divider start
  always_comb begin
    cmd_ready       = (st_r == ST_IDLE) && rb_empty;
    div_start       = (st_r == ST_DIV) && pp_use;
    rb_wr.wr        = 1'b0;
    rb_wr.commit    = 1'b0;
    rb_wr.rec.kind  = K_PASS_DONE;
    rb_wr.rec.id    = '0;
    rb_wr.rec.chan  = '0;
    rb_wr.rec.cslot = '0;
    rb_wr.busy      = owner_vld_r;
    rb_wr.inflight  = 5'(32'(pend_cnt_r) + 32'(active_r));
    unique case (st_r)
      ST_IDLE: begin
        if (take && (cmd.op == OP_ISSUE)) begin
          rb_wr.wr = 1'b1;
          if (cmd.err) rb_wr.rec.kind = K_ERROR;
          else if (credit_fail) rb_wr.rec.kind = K_NO_CREDIT;
          else if (id_full) rb_wr.rec.kind = K_ERROR;
          else begin
            rb_wr.rec.kind = K_ACCEPTED;
            rb_wr.rec.id   = next_id_r;
          end
        end
      end
      ST_SEARCH: begin
        if (srch_end || srch_hit) begin
          rb_wr.wr       = 1'b1;
          rb_wr.rec.kind = srch_end ? K_CANCEL_FAIL : K_CANCELLED;
          rb_wr.rec.id   = tid_r;
        end
      end
      ST_SCAN: begin
        if (cmp_emit) begin
          rb_wr.wr        = 1'b1;
          rb_wr.rec.kind  = K_COMPLETED;
          rb_wr.rec.id    = sinfo_r[cur_s].id;
          rb_wr.rec.chan  = 2'(chan_r);
          rb_wr.rec.cslot = 1'(sub_r);
        end
      end
      ST_FINAL: begin
        rb_wr.wr     = 1'b1;
        rb_wr.commit = 1'b1;
      end
      default: ;
    endcase
  end

  dts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (33'(sinfo_r[last_served_r].bits) + 33'(pw_sel) - 33'd1),
    .divisor  (pw_sel),
    .done     (div_done),
    .quo      (div_q)
  );

  // pending queue and slot payload storage
  always_ff @(posedge clk) begin
    if (pop_en) begin
      for (int i = 0; i < PENDING_DEPTH - 1; i++) begin
        if (PW'(i) >= pop_at) pend_r[i] <= pend_r[i + 1];
      end
    end
    if ((st_r == ST_IDLE) && take && (cmd.op == OP_ISSUE) && acc_ok) begin
      pend_r[pend_cnt_r[PIW-1:0]] <= '{id: next_id_r, bits: cmd.bits, mask: cmd.mask};
    end
    if ((st_r == ST_ADMIT) && adm_go && adm_free) begin
      sinfo_r[cur_s]       <= pend_r[0];
      launch_done_r[cur_s] <= cycle_now_r + CYC_W'(cfg.launch);
    end
    if ((st_r == ST_DIVW) && div_done) begin
      port_done_r[pp_r] <= cycle_now_r + CYC_W'(div_q);
    end
    if ((st_r == ST_IDLE) && take) begin
      tid_r <= cmd.tid;
    end
  end

  // control state and sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= ST_IDLE;
      cycle_now_r   <= '0;
      next_id_r     <= '0;
      pend_cnt_r    <= '0;
      for (int s = 0; s < NSLOTS; s++) phase_r[s] <= PH_FREE;
      owner_vld_r   <= '0;
      last_served_r <= SW'(NSLOTS - 1);
      active_r      <= '0;
      idx_r         <= '0;
      sub_r         <= '0;
      chan_r        <= '0;
      pidx_r        <= '0;
      prog_r        <= 1'b0;
      nrec_r        <= '0;
      rr_r          <= '0;
      rr_cnt_r      <= '0;
      pp_r          <= '0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        ST_IDLE: begin
          if (take) begin
            idx_r  <= '0;
            sub_r  <= '0;
            chan_r <= '0;
            pidx_r <= '0;
            prog_r <= 1'b0;
            nrec_r <= (cmd.op == OP_ISSUE) ? 4'd1 : 4'd0;
            if (cmd.op == OP_ISSUE && acc_ok) begin
              pend_cnt_r <= pend_cnt_r + PW'(1);
              next_id_r  <= next_id_r + 32'd1;
            end
            if (cmd.op == OP_TICK) cycle_now_r <= cycle_now_r + CYC_W'(1);
          end
        end
        ST_SEARCH: begin
          if (srch_end || srch_hit) begin
            nrec_r <= nrec_r + 4'd1;
            if (!srch_end) pend_cnt_r <= pend_cnt_r - PW'(1);
          end else begin
            pidx_r <= pidx_r + PW'(1);
          end
        end
        ST_SCAN: begin
          if (phase_r[cur_s] == PH_XMIT) begin
            for (int p = 0; p < NPORTS; p++) begin
              if (fr[p]) owner_vld_r[p] <= 1'b0;
            end
            if (fr != '0) prog_r <= 1'b1;
            if (xmit_done) begin
              phase_r[cur_s] <= PH_FREE;
              active_r       <= active_r - CW'(1);
              prog_r         <= 1'b1;
              if (cmp_emit) nrec_r <= nrec_r + 4'd1;
            end
          end else if (launch_ok) begin
            phase_r[cur_s] <= PH_WAIT;
            prog_r         <= 1'b1;
          end
          if (scan_last) begin
            idx_r <= '0;
          end else begin
            idx_r <= idx_r + CW'(1);
            if (sub_r == SBW'(SLOTS_PER_CHANNEL - 1)) begin
              sub_r  <= '0;
              chan_r <= chan_r + CHW'(1);
            end else begin
              sub_r <= sub_r + SBW'(1);
            end
          end
        end
        ST_ADMIT: begin
          if (adm_go) begin
            if (adm_free) begin
              pend_cnt_r     <= pend_cnt_r - PW'(1);
              phase_r[cur_s] <= PH_LAUNCH;
              active_r       <= active_r + CW'(1);
              prog_r         <= 1'b1;
            end
            idx_r <= idx_r + CW'(1);
          end else begin
            rr_r     <= rr_inc(last_served_r);
            rr_cnt_r <= '0;
          end
        end
        ST_PICK: begin
          if (rr_ok) begin
            phase_r[rr_r] <= PH_XMIT;
            for (int p = 0; p < NPORTS; p++) begin
              if (sinfo_r[rr_r].mask[p]) begin
                owner_vld_r[p] <= 1'b1;
                owner_r[p]     <= rr_r;
              end
            end
            last_served_r <= rr_r;
            prog_r        <= 1'b1;
            pp_r          <= '0;
          end else begin
            rr_r     <= rr_inc(rr_r);
            rr_cnt_r <= rr_cnt_r + CW'(1);
            if (pick_end) begin
              idx_r  <= '0;
              sub_r  <= '0;
              chan_r <= '0;
              prog_r <= 1'b0;
            end
          end
        end
        ST_DIV: begin
          if (pp_end) begin
            rr_r     <= rr_inc(last_served_r);
            rr_cnt_r <= '0;
          end else if (!pp_use) begin
            pp_r <= pp_r + 3'd1;
          end
        end
        ST_DIVW: begin
          if (div_done) pp_r <= pp_r + 3'd1;
        end
        ST_FINAL: ;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_final_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FINAL) |=> (st_r == ST_IDLE))
    else $error("pass end did not return to idle");
  a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(active_r) <= NSLOTS)
    else $error("active count above slot count");
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pend_cnt_r) <= PENDING_DEPTH)
    else $error("pending count above depth");
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == ST_DIVW))
    else $error("divider result outside wait state");
`endif

endmodule
`default_nettype wire

FILE: src/dma_transfer_slot_scheduler_top.sv
// dma_transfer_slot_scheduler_top: transfer slot scheduler, top level
// depends on dts_pkg, dts_front, dts_engine, dts_rbuf
//
// Usage: input words (issue, cancel, tick) enter on in_valid/in_stall with
// in_data; each word yields its records on out_valid/out_stall with out_data,
// the final one marked by last and always of kind pass done. Registers are
// written on cfg_valid/cfg_ready (always ready) with cfg_index and cfg_data,
// by the user only while the block is idle; the block does not enforce it.
// A two-word input queue takes words while the engine works; the engine runs
// one word at a time. Each word is started, a cancel then searches the
// pending queue, and each pass round scans all NSLOTS slots, admits into
// the used slots and checks NSLOTS slots round-robin; each started transfer
// is picked, then runs the 33-step divider once per port it uses, skips the
// ports it does not use and closes.
// Records then leave one per cycle while out_stall is low.
// Reset (synchronous, rst_n low) frees all slots and ports, empties the
// queues and loads register defaults. While out_stall is high the current
// record holds; the engine waits for the buffer to drain before the next word.
`timescale 1ns / 1ps
`default_nettype none
module dma_transfer_slot_scheduler_top #(
  parameter int MAX_CHANNELS      = 4,
  parameter int SLOTS_PER_CHANNEL = 2,
  parameter int PENDING_DEPTH     = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dts_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import dts_pkg::*;

  cfg_t   cfg_r;
  cmd_t   cmd;
  logic   cmd_valid, cmd_ready, rb_empty;
  rb_wr_t rb_wr;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fine     <= 1'b0;
      cfg_r.chan_cnt <= 3'd4;
      cfg_r.launch   <= 16'd0;
      cfg_r.bus_w    <= 13'd64;
      cfg_r.spm_rd_w <= 13'd64;
      cfg_r.spm_wr_w <= 13'd64;
      cfg_r.axi_rd_w <= 13'd64;
      cfg_r.axi_wr_w <= 13'd64;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FINE:     cfg_r.fine     <= cfg_data[0];
        CFG_CHANNELS: cfg_r.chan_cnt <= cfg_data[2:0];
        CFG_LAUNCH:   cfg_r.launch   <= cfg_data;
        CFG_BUS_W:    cfg_r.bus_w    <= cfg_data[12:0];
        CFG_SPM_RD_W: cfg_r.spm_rd_w <= cfg_data[12:0];
        CFG_SPM_WR_W: cfg_r.spm_wr_w <= cfg_data[12:0];
        CFG_AXI_RD_W: cfg_r.axi_rd_w <= cfg_data[12:0];
        CFG_AXI_WR_W: cfg_r.axi_wr_w <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  dts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  dts_engine #(
    .MAX_CHANNELS      (MAX_CHANNELS),
    .SLOTS_PER_CHANNEL (SLOTS_PER_CHANNEL),
    .PENDING_DEPTH     (PENDING_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rb_empty  (rb_empty),
    .rb_wr     (rb_wr)
  );

  dts_rbuf u_rbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .rb_wr     (rb_wr),
    .rb_empty  (rb_empty),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: tb/tb.sv
// tb: self-checking bench for the transfer slot scheduler top level
// depends on dts_pkg and dma_transfer_slot_scheduler_top; predicts every record in-bench
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import dts_pkg::*;

  localparam int NSLOT = 8;
  localparam int NPRT  = 5;
  localparam int PDEPTH = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  dma_transfer_slot_scheduler_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // scheduler mirror: registers
  logic        m_fine = 1'b0;
  logic [2:0]  m_chan = 3'd4;
  logic [15:0] m_launch = '0;
  logic [12:0] m_width [NPRT] = '{64, 64, 64, 64, 64};

  // scheduler mirror: state
  logic [47:0] now_cyc = '0;
  logic [31:0] next_tid = '0;
  logic [31:0] pend_id [PDEPTH];
  logic [31:0] pend_bits [PDEPTH];
  logic [4:0]  pend_mask [PDEPTH];
  int          pend_n = 0;
  phase_t      phase [NSLOT] = '{default: PH_FREE};
  logic [31:0] slot_id [NSLOT];
  logic [31:0] slot_bits [NSLOT];
  logic [4:0]  slot_mask [NSLOT];
  logic [4:0]  slot_left [NSLOT];
  logic [47:0] launch_at [NSLOT];
  logic [47:0] port_at [NSLOT][NPRT];
  int          owner [NPRT] = '{default: 0};
  int          rr_last = NSLOT - 1;
  int          active_n = 0;

  // records of the word being predicted
  kind_t       rec_kind [9];
  logic [31:0] rec_id [9];
  int          rec_slot [9];
  int          rec_n;

  out_item_t   expected_recs [$];
  int          errors = 0;
  int          burst_left = 0;
  int          stall_mode = 0;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          stall_ph = 0;

  function automatic logic due(input logic [47:0] at);
    logic [47:0] d;
    d = now_cyc - at;
    return !d[47];
  endfunction

  function automatic int used_slots();
    int c;
    c = (m_chan == 0) ? 1 : ((m_chan > 4) ? 4 : m_chan);
    return c * 2;
  endfunction

  task automatic add_rec(input kind_t k, input logic [31:0] id, input int s);
    if (rec_n < 9) begin
      rec_kind[rec_n] = k;
      rec_id[rec_n] = id;
      rec_slot[rec_n] = s;
      rec_n++;
    end
  endtask

  // full scheduling step for one accepted word, records queued in order
  task automatic predict_word(input in_item_t w);
    logic [4:0]  mask;
    logic [4:0]  busy;
    logic [63:0] wd, cyc;
    logic        prog, hit, pfree;
    int          s, p, i, c, k, pick;
    out_item_t   r;
    rec_n = 0;
    if (w.operation == OP_ISSUE) begin
      if (w.payload_size == 0 || w.direction > 5 || (!m_fine && w.direction > 1))
        add_rec(K_ERROR, 0, 0);
      else if (pend_n + active_n >= used_slots() + PDEPTH || pend_n >= PDEPTH)
        add_rec(K_NO_CREDIT, 0, 0);
      else if (next_tid == 32'hFFFF_FFFF)
        add_rec(K_ERROR, 0, 0);
      else begin
        case (w.direction)
          DIR_SPM_REMOTE:  mask = 5'h02;
          DIR_REMOTE_SPM:  mask = 5'h04;
          DIR_SPM_SPM:     mask = 5'h06;
          DIR_SPM_DRAM:    mask = 5'h12;
          DIR_DRAM_SPM:    mask = 5'h0C;
          default:         mask = 5'h08;
        endcase
        if (!m_fine) mask = 5'h01;
        pend_id[pend_n] = next_tid;
        pend_bits[pend_n] = w.payload_size;
        pend_mask[pend_n] = mask;
        pend_n++;
        add_rec(K_ACCEPTED, next_tid, 0);
        next_tid++;
      end
    end else if (w.operation == OP_CANCEL) begin
      hit = 1'b0;
      for (i = 0; i < pend_n && !hit; i++)
        if (pend_id[i] == w.target_id) begin
          for (k = i; k < pend_n - 1; k++) begin
            pend_id[k] = pend_id[k+1];
            pend_bits[k] = pend_bits[k+1];
            pend_mask[k] = pend_mask[k+1];
          end
          pend_n--;
          hit = 1'b1;
        end
      add_rec(hit ? K_CANCELLED : K_CANCEL_FAIL, w.target_id, 0);
    end else if (w.operation == OP_TICK) begin
      now_cyc = now_cyc + 1;
    end

    do begin
      prog = 1'b0;
      // release finished ports, report freed slots
      for (s = 0; s < NSLOT; s++) begin
        if (phase[s] != PH_XMIT) continue;
        for (p = 0; p < NPRT; p++)
          if (slot_left[s][p] && due(port_at[s][p])) begin
            if (owner[p] == s + 1) owner[p] = 0;
            slot_left[s][p] = 1'b0;
            prog = 1'b1;
          end
        if (slot_left[s] != 0) continue;
        phase[s] = PH_FREE;
        if (active_n > 0) active_n--;
        if (rec_n < 8) add_rec(K_COMPLETED, slot_id[s], s);
        prog = 1'b1;
      end
      // launch latency over
      for (s = 0; s < NSLOT; s++)
        if (phase[s] == PH_LAUNCH && due(launch_at[s])) begin
          phase[s] = PH_WAIT;
          prog = 1'b1;
        end
      // admit queued transfers into free slots
      for (s = 0; s < used_slots() && pend_n > 0; s++) begin
        if (phase[s] != PH_FREE) continue;
        slot_id[s] = pend_id[0];
        slot_bits[s] = pend_bits[0];
        slot_mask[s] = pend_mask[0];
        for (k = 0; k < pend_n - 1; k++) begin
          pend_id[k] = pend_id[k+1];
          pend_bits[k] = pend_bits[k+1];
          pend_mask[k] = pend_mask[k+1];
        end
        pend_n--;
        phase[s] = PH_LAUNCH;
        launch_at[s] = now_cyc + {32'd0, m_launch};
        active_n++;
        prog = 1'b1;
      end
      // round-robin start of waiting slots
      forever begin
        pick = -1;
        for (k = 1; k <= NSLOT && pick < 0; k++) begin
          c = (rr_last + k) % NSLOT;
          pfree = 1'b1;
          for (p = 0; p < NPRT; p++)
            if (slot_mask[c][p] && owner[p] != 0) pfree = 1'b0;
          if (phase[c] == PH_WAIT && pfree) pick = c;
        end
        if (pick < 0) break;
        phase[pick] = PH_XMIT;
        slot_left[pick] = slot_mask[pick];
        for (p = 0; p < NPRT; p++)
          if (slot_mask[pick][p]) begin
            wd = (m_width[p] == 0) ? 64'd1 : {51'd0, m_width[p]};
            cyc = ({32'd0, slot_bits[pick]} + wd - 1) / wd;
            owner[p] = pick + 1;
            port_at[pick][p] = now_cyc + cyc[47:0];
          end
        rr_last = pick;
        prog = 1'b1;
      end
    end while (prog);

    if (rec_n >= 9) rec_n = 8;
    add_rec(K_PASS_DONE, 0, 0);
    busy = '0;
    for (p = 0; p < NPRT; p++)
      if (owner[p] != 0) busy[p] = 1'b1;
    for (k = 0; k < rec_n; k++) begin
      r.kind = rec_kind[k];
      r.transfer_id = rec_id[k];
      r.channel = (rec_kind[k] == K_COMPLETED) ? 2'(rec_slot[k] / 2) : 2'd0;
      r.slot_in_chan = (rec_kind[k] == K_COMPLETED) ? 1'(rec_slot[k] % 2) : 1'b0;
      r.busy_ports = busy;
      r.inflight = 5'(pend_n + active_n);
      r.last = (k == rec_n - 1);
      expected_recs = {expected_recs, r};
    end
  endtask

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // compare each record leaving the block
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_recs.size() == 0) report("unexpected record", out_data.kind, 0);
      else begin
        e = expected_recs[0];
        expected_recs.delete(0);
        if (out_data.kind !== e.kind) report("kind", out_data.kind, e.kind);
        if (out_data.transfer_id !== e.transfer_id)
          report("transfer_id", out_data.transfer_id, e.transfer_id);
        if (out_data.channel !== e.channel) report("channel", out_data.channel, e.channel);
        if (out_data.slot_in_chan !== e.slot_in_chan)
          report("slot_in_chan", out_data.slot_in_chan, e.slot_in_chan);
        if (out_data.busy_ports !== e.busy_ports)
          report("busy_ports", out_data.busy_ports, e.busy_ports);
        if (out_data.inflight !== e.inflight) report("inflight", out_data.inflight, e.inflight);
        if (out_data.last !== e.last) report("last", out_data.last, e.last);
      end
    end
  end

  // receiver stall patterns plus long hold-offs on request
  always @(posedge clk) begin
    stall_ph <= stall_ph + 1;
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= (stall_ph % 5 < 2);
        3:       out_stall <= ($urandom_range(0, 9) < 6);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // one word through the input channel, then maybe a gap
  task automatic send_word(input op_t op, input logic [31:0] size,
                           input logic [2:0] dir, input logic [31:0] tid);
    in_item_t w;
    w.operation = op;
    w.payload_size = size;
    w.direction = dir;
    w.target_id = tid;
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(w);
    if (burst_left > 0) burst_left--;
    else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // wait until every record has come back and the engine has settled
  task automatic settle();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (expected_recs.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_FINE:     m_fine = d[0];
      CFG_CHANNELS: m_chan = d[2:0];
      CFG_LAUNCH:   m_launch = d;
      default:      m_width[int'(idx) - 3] = d[12:0];
    endcase
  endtask

  task automatic drain_ticks();
    int n;
    n = 0;
    while (pend_n + active_n > 0 && n < 3000) begin
      send_word(OP_TICK, 0, 0, 0);
      n++;
    end
    settle();
  endtask

  // legacy defaults: errors, legal issues, unused operation, cancel misses
  task automatic test_legacy_basics();
    stall_mode = 1;
    send_word(OP_ISSUE, 32'd0, DIR_SPM_REMOTE, 0);
    send_word(OP_ISSUE, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF);
    send_word(OP_ISSUE, 32'd100, 3'd6, 0);
    send_word(OP_ISSUE, 32'd100, DIR_SPM_SPM, 0);
    send_word(OP_ISSUE, 32'd64, DIR_SPM_REMOTE, 0);
    send_word(OP_ISSUE, 32'd130, DIR_REMOTE_SPM, 0);
    send_word(OP_CANCEL, 0, 0, 32'd0);
    send_word(OP_CANCEL, 0, 0, 32'hFFFF_FFFF);
    send_word(OP_NONE, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF);
    drain_ticks();
  endtask

  // two slots busy, a huge transfer waits in the queue and is cancelled
  task automatic test_cancel_pending();
    logic [31:0] first;
    write_reg(CFG_CHANNELS, 16'd1);
    stall_mode = 2;
    first = next_tid;
    send_word(OP_ISSUE, 32'd10, DIR_SPM_REMOTE, 0);
    send_word(OP_ISSUE, 32'd10, DIR_REMOTE_SPM, 0);
    send_word(OP_ISSUE, 32'hFFFF_FFFF, DIR_SPM_REMOTE, 0);
    send_word(OP_ISSUE, 32'd5, DIR_SPM_REMOTE, 0);
    send_word(OP_CANCEL, 0, 0, first + 2);
    send_word(OP_CANCEL, 0, 0, first);
    drain_ticks();
  endtask

  // fill queue past credit with a launch delay holding the slots
  task automatic test_credit();
    int i;
    write_reg(CFG_LAUNCH, 16'd10);
    stall_mode = 0;
    for (i = 0; i < 12; i++) send_word(OP_ISSUE, 32'd8, DIR_SPM_REMOTE, 0);
    drain_ticks();
    write_reg(CFG_LAUNCH, 16'hFFFF);
    send_word(OP_TICK, 0, 0, 0);
    send_word(OP_CANCEL, 0, 0, 32'h5A5A_A5A5);
    settle();
    write_reg(CFG_LAUNCH, 16'd0);
  endtask

  // fine-grained ports at extreme and zero widths, all directions
  task automatic test_fine_ports();
    int d;
    write_reg(CFG_FINE, 16'd1);
    write_reg(CFG_CHANNELS, 16'd7);
    write_reg(CFG_SPM_RD_W, 16'd1);
    write_reg(CFG_SPM_WR_W, 16'd0);
    write_reg(CFG_AXI_RD_W, 16'd4096);
    write_reg(CFG_AXI_WR_W, 16'h2000);
    write_reg(CFG_BUS_W, 16'd4096);
    stall_mode = 3;
    for (d = 0; d < 6; d++) send_word(OP_ISSUE, 32'd6 + d, 3'(d), 0);
    send_word(OP_ISSUE, 32'd9000, DIR_DRAM_REMOTE, 0);
    drain_ticks();
    write_reg(CFG_CHANNELS, 16'd0);
  endtask

  // long receiver hold-off while words keep coming
  task automatic test_backpressure();
    int i;
    stall_mode = 0;
    hold_reqs++;
    for (i = 0; i < 30; i++)
      send_word(i % 3 == 2 ? OP_TICK : OP_ISSUE, 32'd3, DIR_SPM_REMOTE, 0);
    drain_ticks();
  endtask

  function automatic logic [15:0] pick_width();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd8;
      3: return 16'd64;
      4: return 16'd4096;
      default: return 16'($urandom_range(1, 8191));
    endcase
  endfunction

  // random phases, each with its own register setting
  task automatic test_random_traffic();
    int ph, i, r, back;
    logic [2:0] dir;
    for (ph = 0; ph < 4; ph++) begin
      write_reg(CFG_FINE, 16'($urandom_range(0, 1)));
      write_reg(CFG_CHANNELS, 16'($urandom_range(0, 7)));
      write_reg(CFG_LAUNCH, 16'($urandom_range(0, 8)));
      write_reg(CFG_BUS_W, pick_width());
      write_reg(CFG_SPM_RD_W, pick_width());
      write_reg(CFG_SPM_WR_W, pick_width());
      write_reg(CFG_AXI_RD_W, pick_width());
      write_reg(CFG_AXI_WR_W, pick_width());
      stall_mode = ph % 4;
      for (i = 0; i < 48; i++) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          dir = m_fine ? 3'($urandom_range(0, 5)) : 3'($urandom_range(0, 1));
          send_word(OP_ISSUE, $urandom_range(1, 24), dir, $urandom);
        end else if (r < 85) send_word(OP_TICK, $urandom, 3'($urandom), $urandom);
        else if (r < 95) begin
          back = (next_tid == 0) ? 0 : $urandom_range(1, next_tid < 12 ? next_tid : 12);
          send_word(OP_CANCEL, $urandom, 3'($urandom), next_tid - back);
        end else if (r < 97) send_word(OP_NONE, $urandom, 3'($urandom), $urandom);
        else send_word(OP_ISSUE, $urandom, 3'($urandom_range(6, 7)), $urandom);
      end
      drain_ticks();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_legacy_basics();
    test_cancel_pending();
    test_credit();
    test_fine_ports();
    test_backpressure();
    test_random_traffic();
    settle();
    if (expected_recs.size() != 0) report("records never returned", expected_recs.size(), 0);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire
